// ----- rtl/fed_pkg.sv -----
// Shared constants and types for the face edge extraction block.
// Depends on nothing; imported by face_edge_extract_dedup.
package fed_pkg;

  localparam int unsigned MAX_EDGES   = 1024;
  localparam int unsigned VERTEX_BITS = 16;
  localparam int unsigned SLOT_W      = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W       = $clog2(MAX_EDGES + 1);
  localparam int unsigned ENTRY_W     = 2 * VERTEX_BITS;
  localparam int unsigned OUT_DATA_W  = 1 + 2 * VERTEX_BITS + 1 + SLOT_W + 1 + CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int unsigned IN_TDATA_W  = ((VERTEX_BITS + 7) / 8) * 8;

  typedef logic [VERTEX_BITS-1:0] vertex_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // One result word before it enters the output register
  typedef struct packed {
    logic    edge_valid;
    vertex_t edge_a;
    vertex_t edge_b;
    logic    edge_new;
    slot_t   edge_slot;
    logic    table_full;
  } res_t;

endpackage

// ----- rtl/face_edge_extract_dedup.sv -----
// Top level: unique edge extraction from a stream of polygon face vertices.
// Depends on fed_pkg and fed_ram (edge table storage).
//
//  channel  dir  tdata                                   tlast        tuser
//  s_axis   in   vertex_id                               face_end     set_end
//  m_axis   out  valid,a,b,new,slot,full,edges_total     last_result  -
//
// Each edge lookup scans the stored table through the RAM read port, one entry
// per cycle; an item with face_end looks up the closing edge as well. Reset
// clears the edge count and face state; the table needs no clearing since
// only entries below the count are read. A stalled m_axis holds the pending
// word in the output register; the block takes a new word once its last
// result is loaded.
module face_edge_extract_dedup (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fed_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // vertex_id
  input  logic                         s_axis_tlast,  // face_end
  input  logic                         s_axis_tuser,  // set_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // edge_valid, edge_a, edge_b, edge_new, edge_slot, table_full, edges_total
  output logic [fed_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast   // last_result
);
  import fed_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  vertex_t first_q, first_d;
  vertex_t prev_q, prev_d;
  logic    in_face_q, in_face_d;
  vertex_t v_q, v_d;
  logic    fend_q, fend_d;
  logic    send_q, send_d;
  logic    close_q, close_d;
  vertex_t x_q, x_d;
  vertex_t y_q, y_d;
  cnt_t    idx_q, idx_d;
  logic    chk_v_q, chk_v_d;
  slot_t   chk_idx_q, chk_idx_d;
  res_t    res_q, res_d;

  logic    out_valid_q, out_valid_d;
  res_t    out_res_q, out_res_d;
  cnt_t    out_total_q, out_total_d;
  logic    out_last_q, out_last_d;

  logic                 ram_we, ram_re;
  slot_t                ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  vertex_t              rd_a, rd_b;
  logic                 hit, in_acc, out_free;

  fed_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EDGES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_a = ram_rdata[VERTEX_BITS-1:0];
  assign rd_b = ram_rdata[ENTRY_W-1:VERTEX_BITS];
  assign hit  = chk_v_q && ((rd_a == x_q && rd_b == y_q) || (rd_b == x_q && rd_a == y_q));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    first_d     = first_q;
    prev_d      = prev_q;
    in_face_d   = in_face_q;
    v_d         = v_q;
    fend_d      = fend_q;
    send_d      = send_q;
    close_d     = close_q;
    x_d         = x_q;
    y_d         = y_q;
    idx_d       = idx_q;
    chk_v_d     = chk_v_q;
    chk_idx_d   = chk_idx_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[SLOT_W-1:0];
    ram_wdata   = {y_q, x_q};
    ram_re      = 1'b0;
    ram_raddr   = idx_q[SLOT_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          v_d     = s_axis_tdata[VERTEX_BITS-1:0];
          fend_d  = s_axis_tlast;
          send_d  = s_axis_tuser;
          close_d = s_axis_tlast;
          prev_d  = s_axis_tdata[VERTEX_BITS-1:0];
          y_d     = s_axis_tdata[VERTEX_BITS-1:0];
          idx_d   = '0;
          chk_v_d = 1'b0;
          if (in_face_q) begin
            x_d     = prev_q;
            state_d = ST_SCAN;
          end else begin
            // first vertex: no edge, report the vertex itself
            first_d          = s_axis_tdata[VERTEX_BITS-1:0];
            res_d            = '0;
            res_d.edge_a     = s_axis_tdata[VERTEX_BITS-1:0];
            res_d.edge_b     = s_axis_tdata[VERTEX_BITS-1:0];
            state_d          = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_d.edge_valid = 1'b1;
          res_d.edge_a     = rd_a;
          res_d.edge_b     = rd_b;
          res_d.edge_new   = 1'b0;
          res_d.edge_slot  = chk_idx_q;
          res_d.table_full = 1'b0;
          chk_v_d          = 1'b0;
          state_d          = ST_EMIT;
        end else if (idx_q < count_q) begin
          // advance: issue the next entry read
          ram_re    = 1'b1;
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[SLOT_W-1:0];
          idx_d     = idx_q + cnt_t'(1);
        end else if (chk_v_q) begin
          chk_v_d = 1'b0;
        end else begin
          res_d.edge_valid = 1'b1;
          res_d.edge_a     = x_q;
          res_d.edge_b     = y_q;
          if (count_q >= cnt_t'(MAX_EDGES)) begin
            // drop: table full
            res_d.edge_new   = 1'b0;
            res_d.edge_slot  = '0;
            res_d.table_full = 1'b1;
          end else begin
            ram_we           = 1'b1;
            res_d.edge_new   = 1'b1;
            res_d.edge_slot  = count_q[SLOT_W-1:0];
            res_d.table_full = 1'b0;
            count_d          = count_q + cnt_t'(1);
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_total_d = count_q;
          out_last_d  = !close_q;
          if (close_q) begin
            close_d = 1'b0;
            x_d     = first_q;
            y_d     = v_q;
            idx_d   = '0;
            chk_v_d = 1'b0;
            state_d = ST_SCAN;
          end else begin
            in_face_d = !fend_q && !send_q;
            if (send_q) begin
              count_d = '0;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      in_face_q   <= 1'b0;
      close_q     <= 1'b0;
      chk_v_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      in_face_q   <= in_face_d;
      close_q     <= close_d;
      chk_v_q     <= chk_v_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    fend_q      <= fend_d;
    send_q      <= send_d;
    x_q         <= x_d;
    y_q         <= y_d;
    chk_idx_q   <= chk_idx_d;
    res_q       <= res_d;
    out_res_q   <= out_res_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_total_q, out_res_q.table_full, out_res_q.edge_slot,
                                       out_res_q.edge_new, out_res_q.edge_b,
                                       out_res_q.edge_a, out_res_q.edge_valid});

endmodule

// ----- rtl/fed_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fed_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
